// ----- rtl/assert_macros.svh -----
// Assertion helpers; the clock is clk and the reset is rst in every user.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/u8om_pkg.sv -----
package u8om_pkg;

  localparam int OFFSET_BITS_DEFAULT = 16;
  localparam int TARGET_BITS = 16;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_DIRECTION = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET    = 1'b1;

  localparam logic       CMD_BYTE = 1'b0;
  localparam logic       CMD_EOL  = 1'b1;
  localparam logic       DIR_UNITS_TO_BYTES = 1'b0;

  localparam logic [15:0] RESULT_MAX = 16'hFFFF;

  localparam logic [7:0] MASK_ASCII = 8'h80;
  localparam logic [7:0] MASK_LEAD2 = 8'hE0;
  localparam logic [7:0] CODE_LEAD2 = 8'hC0;
  localparam logic [7:0] MASK_LEAD3 = 8'hF0;
  localparam logic [7:0] CODE_LEAD3 = 8'hE0;
  localparam logic [7:0] MASK_LEAD4 = 8'hF8;
  localparam logic [7:0] CODE_LEAD4 = 8'hF0;
  localparam logic [7:0] MASK_CONT  = 8'hC0;
  localparam logic [7:0] CODE_CONT  = 8'h80;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] converted_offset;
    logic        overflow;
  } out_beat_t;

  typedef struct packed {
    logic                   direction;
    logic [TARGET_BITS-1:0] target_offset;
  } cfg_t;

  // 1: single byte, 2..4: sequence length, 0: bad lead
  function automatic logic [2:0] lead_len(logic [7:0] b);
    logic [2:0] len;
    priority if ((b & MASK_ASCII) == 8'h00) len = 3'd1;
    else if ((b & MASK_LEAD2) == CODE_LEAD2) len = 3'd2;
    else if ((b & MASK_LEAD3) == CODE_LEAD3) len = 3'd3;
    else if ((b & MASK_LEAD4) == CODE_LEAD4) len = 3'd4;
    else len = 3'd0;
    return len;
  endfunction

  function automatic logic is_cont(logic [7:0] b);
    return (b & MASK_CONT) == CODE_CONT;
  endfunction

endpackage

// ----- rtl/u8om_in_reg.sv -----
module u8om_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  u8om_pkg::in_beat_t in_beat,
  input  logic               advance,
  output logic               held_valid,
  output u8om_pkg::in_beat_t held_beat
);

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_beat <= in_beat;
    end
  end

endmodule

// ----- rtl/u8om_walker.sv -----
`include "assert_macros.svh"

module u8om_walker #(
  parameter int OFFSET_BITS = u8om_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  u8om_pkg::in_beat_t  beat,
  input  u8om_pkg::cfg_t      cfg,
  output logic                res_valid,
  output u8om_pkg::out_beat_t res_beat
);

  localparam int OB = OFFSET_BITS;
  localparam int CW = ((OB > u8om_pkg::TARGET_BITS) ? OB : u8om_pkg::TARGET_BITS) + 2;

  typedef struct packed {
    logic [OB-1:0] bc;
    logic [OB-1:0] uc;
    logic          reached;
    logic          sat;
  } walk_t;

  function automatic walk_t take_char(walk_t s, logic [2:0] nb, logic [1:0] nu,
                                      logic dir, logic [u8om_pkg::TARGET_BITS-1:0] tgt);
    walk_t         r;
    logic [CW-1:0] uc_x;
    logic [CW-1:0] bc_x;
    logic [CW-1:0] tg_x;
    logic [CW-1:0] un_x;
    logic [OB:0]   bs;
    logic [OB:0]   us;
    r    = s;
    uc_x = CW'(s.uc);
    bc_x = CW'(s.bc);
    tg_x = CW'(tgt);
    un_x = uc_x + CW'(nu);
    bs   = {1'b0, s.bc} + (OB+1)'(nb);
    us   = {1'b0, s.uc} + (OB+1)'(nu);
    if (!s.reached) begin
      if ((dir == u8om_pkg::DIR_UNITS_TO_BYTES && (uc_x >= tg_x || un_x > tg_x)) ||
          (dir != u8om_pkg::DIR_UNITS_TO_BYTES && bc_x >= tg_x)) begin
        r.reached = 1'b1;
      end else begin
        r.bc  = bs[OB] ? '1 : bs[OB-1:0];
        r.uc  = us[OB] ? '1 : us[OB-1:0];
        r.sat = s.sat | bs[OB] | us[OB];
      end
    end
    return r;
  endfunction

  walk_t      walk;
  walk_t      walk_next;
  logic [1:0] pcnt;
  logic [1:0] pcnt_next;
  logic [2:0] elen;
  logic [2:0] elen_next;
  logic [7:0] pb0;
  logic [7:0] pb1;

  logic       open_seq;
  logic       cont;
  logic       do_flush;
  logic [2:0] ll;
  logic [1:0] cp_units;
  walk_t      wa;
  walk_t      w1;
  walk_t      wb;
  walk_t      w2;
  walk_t      wc;
  walk_t      wf;
  walk_t      wt;
  logic [2:0] t_nb;
  logic [1:0] t_nu;
  logic       t_en;
  logic       store;
  logic [CW-1:0] res_x;
  logic       clamp;

  assign open_seq = (elen != 3'd0) && (pcnt != 2'd0);
  assign cont     = u8om_pkg::is_cont(beat.data_byte);
  assign do_flush = (beat.command == u8om_pkg::CMD_EOL) || (open_seq && !cont);
  assign ll       = u8om_pkg::lead_len(beat.data_byte);
  assign cp_units = (elen == 3'd4 && (pb0[2:0] != 3'd0 || pb1[5:4] != 2'd0)) ? 2'd2 : 2'd1;

  // replay held bytes as replacement characters
  assign wa = take_char(walk, 3'd1, 2'd1, cfg.direction, cfg.target_offset);
  assign w1 = (do_flush && pcnt >= 2'd1) ? wa : walk;
  assign wb = take_char(w1, 3'd1, 2'd1, cfg.direction, cfg.target_offset);
  assign w2 = (do_flush && pcnt >= 2'd2) ? wb : w1;
  assign wc = take_char(w2, 3'd1, 2'd1, cfg.direction, cfg.target_offset);
  assign wf = (do_flush && pcnt == 2'd3) ? wc : w2;

  always_comb begin
    t_en      = 1'b0;
    t_nb      = 3'd1;
    t_nu      = 2'd1;
    store     = 1'b0;
    pcnt_next = pcnt;
    elen_next = elen;
    if (beat.command == u8om_pkg::CMD_EOL) begin
      pcnt_next = 2'd0;
      elen_next = 3'd0;
    end else if (open_seq && cont) begin
      if (({1'b0, pcnt} + 3'd1) < elen && pcnt < 2'd3) begin
        store     = 1'b1;
        pcnt_next = pcnt + 2'd1;
      end else begin
        t_en      = 1'b1;
        t_nb      = elen;
        t_nu      = cp_units;
        pcnt_next = 2'd0;
        elen_next = 3'd0;
      end
    end else if (ll == 3'd1 || ll == 3'd0) begin
      t_en      = 1'b1;
      pcnt_next = 2'd0;
      elen_next = 3'd0;
    end else begin
      pcnt_next = 2'd1;
      elen_next = ll;
    end
  end

  assign wt = t_en ? take_char(wf, t_nb, t_nu, cfg.direction, cfg.target_offset) : wf;

  always_comb begin
    if (beat.command == u8om_pkg::CMD_EOL) begin
      walk_next = '0;
    end else begin
      walk_next = wt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk <= '0;
      pcnt <= 2'd0;
      elen <= 3'd0;
    end else if (fire) begin
      walk <= walk_next;
      pcnt <= pcnt_next;
      elen <= elen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && beat.command == u8om_pkg::CMD_BYTE) begin
      if (store) begin
        if (pcnt == 2'd1) begin
          pb1 <= beat.data_byte;
        end
      end else if (!(open_seq && cont) && ll != 3'd1 && ll != 3'd0) begin
        pb0 <= beat.data_byte;
      end
    end
  end

  assign res_x = (cfg.direction == u8om_pkg::DIR_UNITS_TO_BYTES) ? CW'(wf.bc) : CW'(wf.uc);
  assign clamp = res_x > CW'(u8om_pkg::RESULT_MAX);

  assign res_valid                 = fire && beat.command == u8om_pkg::CMD_EOL;
  assign res_beat.converted_offset = clamp ? u8om_pkg::RESULT_MAX : res_x[15:0];
  assign res_beat.overflow         = wf.sat | clamp;

  `ASSERT_NEXT(a_line_cleared, res_valid, walk == '0 && pcnt == 2'd0 && elen == 3'd0, "line state not cleared after end of line")
  `ASSERT_IMPLIES(a_open_pair, 1'b1, (pcnt == 2'd0) == (elen == 3'd0), "held count and sequence length disagree")
  `ASSERT_IMPLIES(a_three_held, pcnt == 2'd3, elen == 3'd4, "three bytes held outside a four-byte sequence")

endmodule

// ----- rtl/u8om_out_reg.sv -----
module u8om_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  u8om_pkg::out_beat_t load_beat,
  output logic                load_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output u8om_pkg::out_beat_t out_beat
);

  assign load_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_ready) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_ready) begin
      out_beat <= load_beat;
    end
  end

endmodule

// ----- rtl/utf8_utf16_offset_mapper_unit.sv -----
// UTF-8 line offset mapper.
// Input channel (in_valid/in_ready/in_beat): one beat per line byte with
// command CMD_BYTE, then one beat with command CMD_EOL that closes the line.
// Output channel (out_valid/out_ready/out_beat): one beat per line, carrying
// the converted offset and the overflow flag.
// Configuration: cfg_we writes cfg_data into the register picked by cfg_index
// (0: direction, 1: target offset); write only while no line is in progress.
// Throughput: one beat per cycle while no end-of-line beat waits on a full
// output register; the cycle time is set by the walker's chain of up to four
// saturating counter updates (three replayed held bytes plus the current
// character).
// Reset clears the configuration, the open sequence and the counters.
// When the receiver stalls, line bytes keep flowing; an end-of-line beat waits
// in the input register until the output register frees, and in_ready drops.
`include "assert_macros.svh"

module utf8_utf16_offset_mapper_unit #(
  parameter int OFFSET_BITS = u8om_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  u8om_pkg::in_beat_t                      in_beat,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output u8om_pkg::out_beat_t                     out_beat,
  input  logic                                    cfg_we,
  input  logic [u8om_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [u8om_pkg::TARGET_BITS-1:0]        cfg_data
);

  u8om_pkg::cfg_t      cfg;
  logic                held_valid;
  u8om_pkg::in_beat_t  held_beat;
  logic                advance;
  logic                res_valid;
  u8om_pkg::out_beat_t res_beat;
  logic                load_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        u8om_pkg::REG_DIRECTION: cfg.direction     <= cfg_data[0];
        u8om_pkg::REG_TARGET:    cfg.target_offset <= cfg_data;
        default:                 cfg               <= cfg;
      endcase
    end
  end

  assign advance = held_valid &&
                   (held_beat.command == u8om_pkg::CMD_BYTE || load_ready);

  u8om_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_beat    (in_beat),
    .advance    (advance),
    .held_valid (held_valid),
    .held_beat  (held_beat)
  );

  u8om_walker #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_walker (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .beat      (held_beat),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_beat  (res_beat)
  );

  u8om_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (res_valid),
    .load_beat  (res_beat),
    .load_ready (load_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_beat   (out_beat)
  );

  `ASSERT_IMPLIES(a_no_lost_result, res_valid, load_ready, "result written into a full output register")
  `ASSERT_NEXT(a_eol_holds, held_valid && held_beat.command == u8om_pkg::CMD_EOL && !load_ready, held_valid && held_beat.command == u8om_pkg::CMD_EOL, "stalled end of line dropped")
  `ASSERT_NEXT(a_result_follows, res_valid, out_valid, "result not presented after end of line")

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import u8om_pkg::*;

  localparam int unsigned COUNT_MAX = (1 << OFFSET_BITS_DEFAULT) - 1;
  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES = 4;

  class line_offset_scoreboard;
    logic              dir;
    logic [15:0]       target;
    logic [7:0]        held [3];
    int unsigned       held_cnt;
    int unsigned       seq_len;
    int unsigned       bytes_walked;
    int unsigned       units_walked;
    bit                stopped;
    bit                saturated;
    out_beat_t         awaited [$];
    int unsigned       mismatches;

    function new();
      dir = DIR_UNITS_TO_BYTES;
      target = '0;
      mismatches = 0;
      clear_line();
    endfunction

    function void clear_line();
      foreach (held[i]) held[i] = '0;
      held_cnt = 0;
      seq_len = 0;
      bytes_walked = 0;
      units_walked = 0;
      stopped = 0;
      saturated = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [TARGET_BITS-1:0] data);
      if (idx == REG_DIRECTION) dir = data[0];
      else if (idx == REG_TARGET) target = data;
    endfunction

    function int unsigned sat_add(int unsigned a, int unsigned b);
      int unsigned sum;
      sum = a + b;
      if (sum > COUNT_MAX) begin
        saturated = 1;
        return COUNT_MAX;
      end
      return sum;
    endfunction

    function void walk_char(int unsigned nbytes, int unsigned nunits);
      if (stopped) return;
      if (dir == DIR_UNITS_TO_BYTES) begin
        if (units_walked >= target || units_walked + nunits > target) begin
          stopped = 1;
          return;
        end
      end else if (bytes_walked >= target) begin
        stopped = 1;
        return;
      end
      bytes_walked = sat_add(bytes_walked, nbytes);
      units_walked = sat_add(units_walked, nunits);
    endfunction

    function void flush_held();
      for (int unsigned i = 0; i < held_cnt; i++) walk_char(1, 1);
      held_cnt = 0;
      seq_len = 0;
    endfunction

    function void open_char(logic [7:0] b);
      if ((b & MASK_ASCII) == 8'h00) begin
        walk_char(1, 1);
        return;
      end
      if ((b & MASK_LEAD2) == CODE_LEAD2) seq_len = 2;
      else if ((b & MASK_LEAD3) == CODE_LEAD3) seq_len = 3;
      else if ((b & MASK_LEAD4) == CODE_LEAD4) seq_len = 4;
      else begin
        walk_char(1, 1);
        return;
      end
      held[0] = b;
      held_cnt = 1;
    endfunction

    function void feed_byte(logic [7:0] b);
      logic [20:0] cp;
      int unsigned len;
      if (seq_len == 0 || held_cnt == 0) begin
        open_char(b);
        return;
      end
      if ((b & MASK_CONT) != CODE_CONT) begin
        flush_held();
        open_char(b);
        return;
      end
      if (held_cnt + 1 < seq_len) begin
        held[held_cnt] = b;
        held_cnt++;
        return;
      end
      len = seq_len;
      if (len == 2) cp = {10'd0, held[0][4:0], b[5:0]};
      else if (len == 3) cp = {5'd0, held[0][3:0], held[1][5:0], b[5:0]};
      else cp = {held[0][2:0], held[1][5:0], held[2][5:0], b[5:0]};
      held_cnt = 0;
      seq_len = 0;
      walk_char(len, (cp > 21'h00FFFF) ? 2 : 1);
    endfunction

    function void note_beat(in_beat_t b);
      int unsigned res;
      out_beat_t exp;
      if (b.command == CMD_BYTE) begin
        feed_byte(b.data_byte);
        return;
      end
      flush_held();
      res = (dir == DIR_UNITS_TO_BYTES) ? bytes_walked : units_walked;
      exp.overflow = saturated;
      if (res > RESULT_MAX) begin
        res = RESULT_MAX;
        exp.overflow = 1'b1;
      end
      exp.converted_offset = res[15:0];
      awaited.push_back(exp);
      clear_line();
    endfunction

    function void check_beat(out_beat_t got);
      out_beat_t exp;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, expected none, got offset %h overflow %b",
                 $time, got.converted_offset, got.overflow);
        mismatches++;
        return;
      end
      exp = awaited.pop_front();
      if (got.converted_offset !== exp.converted_offset) begin
        $display("%0t: converted_offset expected %h got %h",
                 $time, exp.converted_offset, got.converted_offset);
        mismatches++;
      end
      if (got.overflow !== exp.overflow) begin
        $display("%0t: overflow expected %b got %b", $time, exp.overflow, got.overflow);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  in_beat_t                   in_beat;
  logic                       out_valid;
  logic                       out_ready;
  out_beat_t                  out_beat;
  logic                       cfg_we;
  logic [CFG_INDEX_BITS-1:0]  cfg_index;
  logic [TARGET_BITS-1:0]     cfg_data;

  line_offset_scoreboard sb;
  logic [7:0]  line_bytes [$];
  int unsigned items_sent;
  bit          sender_idle_en;
  bit          receiver_idle_en;
  bit          hold_request;
  logic        result_taken;
  out_beat_t   result_seen;

  utf8_utf16_offset_mapper_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(negedge clk) begin
    result_taken <= out_valid && out_ready && !rst;
    result_seen <= out_beat;
  end

  always @(posedge clk) begin
    if (result_taken) sb.check_beat(result_seen);
  end

  initial begin
    int unsigned n;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_request = 0;
      end else begin
        n = $urandom_range(1, 10);
        if (receiver_idle_en && $urandom_range(0, 2) == 0) out_ready <= 1'b0;
        else out_ready <= 1'b1;
        repeat (n - 1) @(posedge clk);
      end
    end
  end

  task automatic offer_beat(in_beat_t b);
    logic ready_seen;
    if (sender_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat <= b;
    do begin
      @(negedge clk);
      ready_seen = in_ready;
      @(posedge clk);
    end while (!ready_seen);
    sb.note_beat(b);
    items_sent++;
  endtask

  task automatic send_line();
    foreach (line_bytes[i])
      offer_beat(in_beat_t'{command: CMD_BYTE, data_byte: line_bytes[i]});
    offer_beat(in_beat_t'{command: CMD_EOL, data_byte: 8'($urandom)});
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [TARGET_BITS-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic program_regs(logic [TARGET_BITS-1:0] dir_word,
                              logic [TARGET_BITS-1:0] target_word);
    write_reg(REG_DIRECTION, dir_word);
    write_reg(REG_TARGET, target_word);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] cont_byte();
    return CODE_CONT | 8'($urandom_range(0, 63));
  endfunction

  task automatic make_line();
    logic [7:0]  chr [$];
    int unsigned nchars;
    bit          noisy;
    int unsigned keep;
    line_bytes.delete();
    nchars = $urandom_range(0, 12);
    noisy = ($urandom_range(0, 4) == 0);
    repeat (nchars) begin
      chr.delete();
      if (noisy && $urandom_range(0, 2) == 0) begin
        chr.push_back(8'($urandom_range(0, 255)));
      end else begin
        case ($urandom_range(0, 3))
          0: chr.push_back(8'($urandom_range(0, 127)));
          1: begin
            chr.push_back(CODE_LEAD2 | 8'($urandom_range(0, 31)));
            chr.push_back(cont_byte());
          end
          2: begin
            chr.push_back(CODE_LEAD3 | 8'($urandom_range(0, 15)));
            repeat (2) chr.push_back(cont_byte());
          end
          default: begin
            chr.push_back(CODE_LEAD4 | 8'($urandom_range(0, 7)));
            repeat (3) chr.push_back(cont_byte());
          end
        endcase
      end
      keep = chr.size();
      if (noisy && $urandom_range(0, 1) == 0) keep = $urandom_range(1, chr.size());
      for (int unsigned i = 0; i < keep; i++) line_bytes.push_back(chr[i]);
    end
  endtask

  function automatic logic [TARGET_BITS-1:0] pick_target();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return RESULT_MAX;
      2: return TARGET_BITS'($urandom);
      default: return TARGET_BITS'($urandom_range(0, 40));
    endcase
  endfunction

  initial begin
    int unsigned lines_left;
    bit          hold_done;
    in_valid <= 1'b0;
    in_beat <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    rst <= 1'b1;
    sb = new();
    items_sent = 0;
    sender_idle_en = 1;
    receiver_idle_en = 1;
    hold_request = 0;
    hold_done = 0;
    lines_left = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // surrogate pair across the target: round down
    program_regs(16'h0000, 16'd1);
    line_bytes = {8'hF0, 8'h9F, 8'h98, 8'h80};
    send_line();
    drain();

    // character straddling a byte target: count whole
    program_regs(16'hFFFF, 16'd1);
    line_bytes = {8'hE2, 8'h82, 8'hAC, 8'h41};
    send_line();
    drain();

    // bad leads, bad continuations with replay, cut sequence at line end
    program_regs(16'hFFFE, 16'hFFFF);
    line_bytes = {8'h80, 8'hFF, 8'hC3, 8'h41, 8'hF0, 8'h90, 8'h80, 8'h41,
                  8'hE2, 8'h82};
    send_line();
    drain();

    program_regs(16'h0001, 16'h0000);
    line_bytes = {8'h00, 8'h7F};
    send_line();
    drain();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (lines_left == 0) begin
        drain();
        program_regs(TARGET_BITS'($urandom), pick_target());
        lines_left = $urandom_range(1, 6);
      end
      if (!hold_done && items_sent > RANDOM_ITEMS / 3) begin
        hold_request = 1;
        hold_done = 1;
        lines_left = 12;
      end
      if (items_sent > RANDOM_ITEMS * 4 / 5) begin
        sender_idle_en = 0;
        receiver_idle_en = 0;
        lines_left = RANDOM_ITEMS;
      end
      make_line();
      send_line();
      lines_left--;
    end
    drain();

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
